>>> rtl/lik_pkg.sv
// shared types, constants and tables of the leg inverse kinematics unit
package lik_pkg;

    localparam int MUL_W    = 28;
    localparam int PROD_W   = 56;
    localparam int SQ_W     = 56;
    localparam int ROOT_W   = 28;
    localparam int CO_IN_W  = 32;
    localparam int CO_W     = 35;
    localparam int CO_Z_W   = 21;
    localparam int CO_STEPS = 18;
    localparam int CO_IDX_W = 5;
    localparam int ANG_W    = 16;

    localparam int DEG90  = 5760;
    localparam int DEG140 = 8960;
    localparam int DEG180 = 11520;

    localparam logic [2:0] REG_FEMUR  = 3'd0;
    localparam logic [2:0] REG_TIBIA  = 3'd1;
    localparam logic [2:0] REG_COXA   = 3'd2;
    localparam logic [2:0] REG_REF_X  = 3'd3;
    localparam logic [2:0] REG_REF_Y  = 3'd4;
    localparam logic [2:0] REG_REF_Z  = 3'd5;
    localparam logic [2:0] REG_HSHIFT = 3'd6;

    localparam logic [18:0] ATAN_TAB [CO_STEPS] = '{
        19'd184320, 19'd108810, 19'd57492, 19'd29184, 19'd14649, 19'd7331,
        19'd3667, 19'd1833, 19'd917, 19'd458, 19'd229, 19'd115,
        19'd57, 19'd29, 19'd14, 19'd7, 19'd4, 19'd2
    };

    localparam logic [7:0] LIM_LO [4][3] = '{
        '{8'd60, 8'd5, 8'd40}, '{8'd5, 8'd60, 8'd20},
        '{8'd5, 8'd60, 8'd20}, '{8'd60, 8'd5, 8'd40}
    };

    localparam logic [7:0] LIM_HI [4][3] = '{
        '{8'd175, 8'd120, 8'd160}, '{8'd120, 8'd175, 8'd140},
        '{8'd120, 8'd175, 8'd140}, '{8'd175, 8'd120, 8'd160}
    };

    localparam logic [7:0] PARK_TIB [4] = '{8'd160, 8'd20, 8'd20, 8'd160};

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef enum logic [5:0] {
        ST_IDLE, ST_SETUP,
        ST_XX, ST_YY, ST_RSUM, ST_RSQ, ST_RWAIT,
        ST_VV, ST_ZZ, ST_DSUM, ST_DSQ, ST_DWAIT,
        ST_G, ST_GWAIT, ST_F1, ST_F1WAIT,
        ST_AA, ST_BB, ST_N1, ST_M1,
        ST_AC_CHK, ST_AC_NN, ST_AC_SUB, ST_AC_SQ, ST_AC_SQW, ST_AC_AT, ST_AC_ATW,
        ST_M2, ST_M2B, ST_MIR, ST_APPLY, ST_PARK, ST_FIN
    } lik_state_t;

endpackage

>>> rtl/lik_isqrt.sv
// iterative floor square root, two result bits per step pair, one step a cycle
module lik_isqrt
    import lik_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SQ_W-1:0]   din,
    output unit_stat_t        stat,
    output logic [ROOT_W-1:0] root
);

    localparam logic [SQ_W-1:0] SQ_TOP = SQ_W'(1) << (SQ_W - 2);

    logic            run_reg, run_next;
    logic            done_reg, done_next;
    logic [SQ_W-1:0] rem_reg, rem_next;
    logic [SQ_W-1:0] res_reg, res_next;
    logic [SQ_W-1:0] bit_reg, bit_next;
    logic [SQ_W-1:0] trial;

    assign trial = res_reg + bit_reg;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (start)
        begin
            run_next = 1'b1;
            rem_next = din;
            res_next = '0;
            bit_next = SQ_TOP;
        end
        else if (run_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign stat.busy = run_reg;
    assign stat.done = done_reg;
    assign root      = res_reg[ROOT_W-1:0];

endmodule

>>> rtl/lik_cordic.sv
// iterative vectoring cordic giving atan2 in 1/64 degree
module lik_cordic
    import lik_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [CO_IN_W-1:0]  y_in,
    input  logic signed [CO_IN_W-1:0]  x_in,
    output unit_stat_t                 stat,
    output logic signed [ANG_W-1:0]    angle
);

    localparam logic signed [CO_W-1:0] NORM_LIM = CO_W'(1) <<< 30;

    logic                       run_reg, run_next;
    logic                       norm_reg, norm_next;
    logic                       fin_reg, fin_next;
    logic                       done_reg, done_next;
    logic                       xneg_reg, xneg_next;
    logic                       ypos_reg, ypos_next;
    logic signed [CO_W-1:0]     ax_reg, ax_next;
    logic signed [CO_W-1:0]     cy_reg, cy_next;
    logic signed [CO_Z_W-1:0]   z_reg, z_next;
    logic [CO_IDX_W-1:0]        i_reg, i_next;
    logic signed [ANG_W-1:0]    res_reg, res_next;

    logic signed [CO_W-1:0]     cy_abs;
    logic signed [CO_W-1:0]     sh_ax;
    logic signed [CO_W-1:0]     sh_cy;
    logic signed [CO_Z_W-1:0]   tab;
    logic signed [CO_Z_W-1:0]   base;
    logic signed [ANG_W:0]      quad;

    assign cy_abs = (cy_reg < 0) ? -cy_reg : cy_reg;
    assign sh_ax  = ax_reg >>> i_reg;
    assign sh_cy  = cy_reg >>> i_reg;
    assign tab    = $signed(CO_Z_W'(ATAN_TAB[i_reg]));
    assign base   = (z_reg + CO_Z_W'(32)) >>> 6;

    always_comb
    begin
        if (!xneg_reg)
            quad = (ANG_W + 1)'(base);
        else if (ypos_reg)
            quad = (ANG_W + 1)'(DEG180) - (ANG_W + 1)'(base);
        else
            quad = -(ANG_W + 1)'(DEG180) - (ANG_W + 1)'(base);
    end

    always_comb
    begin
        run_next  = run_reg;
        norm_next = norm_reg;
        fin_next  = fin_reg;
        done_next = 1'b0;
        xneg_next = xneg_reg;
        ypos_next = ypos_reg;
        ax_next   = ax_reg;
        cy_next   = cy_reg;
        z_next    = z_reg;
        i_next    = i_reg;
        res_next  = res_reg;
        if (start)
        begin
            if (y_in == 0)
            begin
                res_next  = (x_in < 0) ? ANG_W'(DEG180) : '0;
                done_next = 1'b1;
            end
            else if (x_in == 0)
            begin
                res_next  = (y_in > 0) ? ANG_W'(DEG90) : -ANG_W'(DEG90);
                done_next = 1'b1;
            end
            else
            begin
                run_next  = 1'b1;
                norm_next = 1'b1;
                fin_next  = 1'b0;
                xneg_next = x_in < 0;
                ypos_next = y_in > 0;
                ax_next   = (x_in < 0) ? -CO_W'(x_in) : CO_W'(x_in);
                cy_next   = CO_W'(y_in);
                z_next    = '0;
                i_next    = '0;
            end
        end
        else if (run_reg)
        begin
            if (fin_reg)
            begin
                res_next  = quad[ANG_W-1:0];
                run_next  = 1'b0;
                fin_next  = 1'b0;
                done_next = 1'b1;
            end
            else if (norm_reg)
            begin
                if (ax_reg < NORM_LIM && cy_abs < NORM_LIM)
                begin
                    ax_next = ax_reg <<< 1;
                    cy_next = cy_reg <<< 1;
                end
                else
                begin
                    norm_next = 1'b0;
                end
            end
            else
            begin
                if (cy_reg > 0)
                begin
                    ax_next = ax_reg + sh_cy;
                    cy_next = cy_reg - sh_ax;
                    z_next  = z_reg + tab;
                end
                else
                begin
                    ax_next = ax_reg - sh_cy;
                    cy_next = cy_reg + sh_ax;
                    z_next  = z_reg - tab;
                end
                i_next = i_reg + 1'b1;
                if (i_reg == CO_IDX_W'(CO_STEPS - 1))
                    fin_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            norm_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            norm_reg <= norm_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xneg_reg <= xneg_next;
        ypos_reg <= ypos_next;
        ax_reg   <= ax_next;
        cy_reg   <= cy_next;
        z_reg    <= z_next;
        i_reg    <= i_next;
        res_reg  <= res_next;
    end

    assign stat.busy = run_reg;
    assign stat.done = done_reg;
    assign angle     = res_reg;

endmodule

>>> rtl/leg_inverse_kinematics_unit.sv
// top level: register port, sequencer, shared multiplier and the two shared units
// One item is taken at a time: s_tready is high only while the sequencer is idle, and the
// result sits in an output register so the next item can be taken while it waits. A move
// runs one solve and a calibrate two full solves; a halted item or an absent leg skips the
// solve. The time is set by the shared square root unit (four roots per solve) and the
// shared cordic (up to 30 normalizing shifts plus 18 rotations, four angles per solve); the
// products run through one multiplier.
module leg_inverse_kinematics_unit
    import lik_pkg::*;
#(
    parameter int NUM_LEGS    = 4,
    parameter int ANGLE_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // pos_x, pos_y, pos_z, zero fill
    input  logic [2:0]  s_tuser,   // opcode, leg
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // hip_angle, femur_angle, tibia_angle
    output logic        m_tuser    // fault
);

    localparam int SW = ((ANGLE_WIDTH > 18) ? ANGLE_WIDTH : 18) + 2;
    localparam logic signed [SW:0]   SAT_HI = (SW + 1)'((64'sd1 <<< (ANGLE_WIDTH - 1)) - 1);
    localparam logic signed [SW:0]   SAT_LO = -SAT_HI - (SW + 1)'(1);
    localparam logic signed [SW-1:0] D90    = SW'(DEG90);
    localparam logic signed [SW-1:0] D140   = SW'(DEG140);

    function automatic logic signed [SW:0] sat_ang(input logic signed [SW:0] v);
        if (v > SAT_HI)
            return SAT_HI;
        if (v < SAT_LO)
            return SAT_LO;
        return v;
    endfunction

    lik_state_t state_reg, state_next;

    logic [11:0] femur_reg, femur_next;
    logic [11:0] tibia_reg, tibia_next;
    logic [11:0] coxa_reg, coxa_next;
    logic [9:0]  refx_reg, refx_next;
    logic [9:0]  refy_reg, refy_next;
    logic [9:0]  refz_reg, refz_next;
    logic [7:0]  hshift_reg, hshift_next;

    logic halted_reg, halted_next;
    logic m_valid_reg, m_valid_next;
    logic signed [ANGLE_WIDTH-1:0] corr_reg [NUM_LEGS][3];
    logic signed [ANGLE_WIDTH-1:0] corr_next [NUM_LEGS][3];

    logic                    op_reg, op_next;
    logic [1:0]              leg_reg, leg_next;
    logic signed [9:0]       px_reg, px_next;
    logic signed [9:0]       py_reg, py_next;
    logic signed [9:0]       pz_reg, pz_next;
    logic                    pass_reg, pass_next;
    logic                    sel_reg, sel_next;
    logic signed [10:0]      sx_reg, sx_next;
    logic signed [10:0]      sy_reg, sy_next;
    logic signed [10:0]      sz_reg, sz_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic signed [15:0]      v_reg, v_next;
    logic signed [29:0]      d2_reg, d2_next;
    logic [14:0]             d_reg, d_next;
    logic [ROOT_W-1:0]       s_reg, s_next;
    logic signed [30:0]      n_reg, n_next;
    logic signed [30:0]      n2_reg, n2_next;
    logic signed [28:0]      m_reg, m_next;
    logic signed [ANG_W-1:0] g_reg, g_next;
    logic signed [ANG_W-1:0] f1_reg, f1_next;
    logic signed [ANG_W-1:0] f2_reg, f2_next;
    logic signed [ANG_W-1:0] t_reg, t_next;
    logic signed [SW-1:0]    ang_reg [3];
    logic signed [SW-1:0]    ang_next [3];
    logic signed [SW-1:0]    ref_reg [3];
    logic signed [SW-1:0]    ref_next [3];
    logic [15:0]             res_reg [3];
    logic [15:0]             res_next [3];
    logic                    res_fault_reg, res_fault_next;
    logic [47:0]             m_data_reg, m_data_next;
    logic                    m_fault_reg, m_fault_next;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic                    sq_start;
    logic [SQ_W-1:0]         sq_din;
    unit_stat_t              sq_stat;
    logic [ROOT_W-1:0]       sq_root;
    logic                    co_start;
    logic signed [CO_IN_W-1:0] co_y, co_x;
    unit_stat_t              co_stat;
    logic signed [ANG_W-1:0] co_angle;

    logic                    cfg_wr;
    logic                    in_acc;
    logic                    leg_absent;
    logic                    inner;
    logic signed [30:0]      n_abs;
    logic                    acos_ok;
    logic signed [14:0]      big_x, big_y, big_z;
    logic signed [ANGLE_WIDTH-1:0] corr_row [3];
    logic signed [SW:0]      sat_val [3];
    logic                    lim_bad;
    logic signed [SW-1:0]    mir [3];
    logic signed [SW-1:0]    fsum;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid & s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_fault_reg;

    assign leg_absent = 32'(leg_reg) >= NUM_LEGS;
    assign inner      = (leg_reg == 2'd1) || (leg_reg == 2'd2);
    assign big_x      = {sx_reg, 4'b0};
    assign big_y      = {sy_reg, 4'b0};
    assign big_z      = {sz_reg, 4'b0};
    assign n_abs      = (n_reg < 0) ? -n_reg : n_reg;
    assign acos_ok    = (m_reg > 0) && (32'(n_abs) <= 32'(m_reg));
    assign prod_next  = mul_a * mul_b;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
            corr_row[j] = '0;
        for (int i = 0; i < NUM_LEGS; i++)
        begin
            if (32'(leg_reg) == i)
            begin
                for (int j = 0; j < 3; j++)
                    corr_row[j] = corr_reg[i][j];
            end
        end
    end

    always_comb
    begin
        lim_bad = 1'b0;
        for (int j = 0; j < 3; j++)
        begin
            if (op_reg)
                sat_val[j] = sat_ang((SW + 1)'(ang_reg[j]) - (SW + 1)'(ref_reg[j]));
            else
                sat_val[j] = sat_ang((SW + 1)'(ang_reg[j]) + (SW + 1)'(corr_row[j]));
            if (sat_val[j] < $signed((SW + 1)'({LIM_LO[leg_reg][j], 6'b0})) ||
                sat_val[j] > $signed((SW + 1)'({LIM_HI[leg_reg][j], 6'b0})))
                lim_bad = 1'b1;
        end
    end

    assign fsum   = SW'(f1_reg) + SW'(f2_reg);
    assign mir[0] = inner ? D90 - SW'(g_reg) : D90 + SW'(g_reg);
    assign mir[1] = inner ? D90 + fsum : D90 - fsum;
    assign mir[2] = inner ? D140 - SW'(t_reg) : SW'(t_reg);

    always_comb
    begin
        prdata = '0;
        unique case (paddr[4:2])
            REG_FEMUR:  prdata = 32'(femur_reg);
            REG_TIBIA:  prdata = 32'(tibia_reg);
            REG_COXA:   prdata = 32'(coxa_reg);
            REG_REF_X:  prdata = 32'(refx_reg);
            REG_REF_Y:  prdata = 32'(refy_reg);
            REG_REF_Z:  prdata = 32'(refz_reg);
            REG_HSHIFT: prdata = 32'(hshift_reg);
            default:    prdata = '0;
        endcase
    end

    always_comb
    begin
        femur_next  = femur_reg;
        tibia_next  = tibia_reg;
        coxa_next   = coxa_reg;
        refx_next   = refx_reg;
        refy_next   = refy_reg;
        refz_next   = refz_reg;
        hshift_next = hshift_reg;
        if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_FEMUR:  femur_next  = pwdata[11:0];
                REG_TIBIA:  tibia_next  = pwdata[11:0];
                REG_COXA:   coxa_next   = pwdata[11:0];
                REG_REF_X:  refx_next   = pwdata[9:0];
                REG_REF_Y:  refy_next   = pwdata[9:0];
                REG_REF_Z:  refz_next   = pwdata[9:0];
                REG_HSHIFT: hshift_next = pwdata[7:0];
                default:    ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_acc)
                    state_next = ST_SETUP;
            ST_SETUP:
                if (halted_reg)
                    state_next = ST_PARK;
                else if (leg_absent)
                    state_next = op_reg ? ST_FIN : ST_PARK;
                else
                    state_next = ST_XX;
            ST_XX:     state_next = ST_YY;
            ST_YY:     state_next = ST_RSUM;
            ST_RSUM:   state_next = ST_RSQ;
            ST_RSQ:    state_next = ST_RWAIT;
            ST_RWAIT:
                if (sq_stat.done)
                    state_next = ST_VV;
            ST_VV:     state_next = ST_ZZ;
            ST_ZZ:     state_next = ST_DSUM;
            ST_DSUM:   state_next = ST_DSQ;
            ST_DSQ:    state_next = ST_DWAIT;
            ST_DWAIT:
                if (sq_stat.done)
                    state_next = ST_G;
            ST_G:      state_next = ST_GWAIT;
            ST_GWAIT:
                if (co_stat.done)
                    state_next = ST_F1;
            ST_F1:     state_next = ST_F1WAIT;
            ST_F1WAIT:
                if (co_stat.done)
                    state_next = ST_AA;
            ST_AA:     state_next = ST_BB;
            ST_BB:     state_next = ST_N1;
            ST_N1:     state_next = ST_M1;
            ST_M1:     state_next = ST_AC_CHK;
            ST_AC_CHK: state_next = acos_ok ? ST_AC_NN : ST_PARK;
            ST_AC_NN:  state_next = ST_AC_SUB;
            ST_AC_SUB: state_next = ST_AC_SQ;
            ST_AC_SQ:  state_next = ST_AC_SQW;
            ST_AC_SQW:
                if (sq_stat.done)
                    state_next = ST_AC_AT;
            ST_AC_AT:  state_next = ST_AC_ATW;
            ST_AC_ATW:
                if (co_stat.done)
                    state_next = sel_reg ? ST_MIR : ST_M2;
            ST_M2:     state_next = ST_M2B;
            ST_M2B:    state_next = ST_AC_CHK;
            ST_MIR:    state_next = (op_reg && !pass_reg) ? ST_XX : ST_APPLY;
            ST_APPLY:  state_next = (!op_reg && lim_bad) ? ST_PARK : ST_FIN;
            ST_PARK:   state_next = ST_FIN;
            ST_FIN:
                if (!m_valid_reg || m_tready)
                    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and unit controls
    always_comb
    begin
        halted_next    = halted_reg;
        m_valid_next   = m_valid_reg;
        corr_next      = corr_reg;
        op_next        = op_reg;
        leg_next       = leg_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        pz_next        = pz_reg;
        pass_next      = pass_reg;
        sel_next       = sel_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        sz_next        = sz_reg;
        acc_next       = acc_reg;
        v_next         = v_reg;
        d2_next        = d2_reg;
        d_next         = d_reg;
        s_next         = s_reg;
        n_next         = n_reg;
        n2_next        = n2_reg;
        m_next         = m_reg;
        g_next         = g_reg;
        f1_next        = f1_reg;
        f2_next        = f2_reg;
        t_next         = t_reg;
        ang_next       = ang_reg;
        ref_next       = ref_reg;
        res_next       = res_reg;
        res_fault_next = res_fault_reg;
        m_data_next    = m_data_reg;
        m_fault_next   = m_fault_reg;
        mul_a          = '0;
        mul_b          = '0;
        sq_start       = 1'b0;
        sq_din         = $unsigned(acc_reg);
        co_start       = 1'b0;
        co_y           = '0;
        co_x           = '0;

        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
                if (in_acc)
                begin
                    op_next  = s_tuser[0];
                    leg_next = s_tuser[2:1];
                    px_next  = s_tdata[9:0];
                    py_next  = s_tdata[19:10];
                    pz_next  = s_tdata[29:20];
                end
            ST_SETUP:
            begin
                pass_next = 1'b0;
                if (op_reg)
                begin
                    sx_next = 11'($signed(refx_reg));
                    sy_next = 11'($signed(refy_reg));
                    sz_next = 11'($signed(refz_reg));
                end
                else
                begin
                    sx_next = 11'(px_reg);
                    sy_next = 11'(py_reg);
                    sz_next = 11'(pz_reg);
                end
                for (int j = 0; j < 3; j++)
                    res_next[j] = '0;
                res_fault_next = 1'b0;
            end
            ST_XX:
            begin
                mul_a = MUL_W'(big_x);
                mul_b = MUL_W'(big_x);
            end
            ST_YY:
            begin
                acc_next = prod_reg;
                mul_a    = MUL_W'(big_y);
                mul_b    = MUL_W'(big_y);
            end
            ST_RSUM:  acc_next = acc_reg + prod_reg;
            ST_RSQ:   sq_start = 1'b1;
            ST_RWAIT:
                if (sq_stat.done)
                    v_next = $signed({1'b0, sq_root[14:0]}) - $signed({4'b0, coxa_reg});
            ST_VV:
            begin
                mul_a = MUL_W'(v_reg);
                mul_b = MUL_W'(v_reg);
            end
            ST_ZZ:
            begin
                acc_next = prod_reg;
                mul_a    = MUL_W'(big_z);
                mul_b    = MUL_W'(big_z);
            end
            ST_DSUM:  d2_next = 30'(acc_reg + prod_reg);
            ST_DSQ:
            begin
                sq_start = 1'b1;
                sq_din   = {26'b0, d2_reg};
            end
            ST_DWAIT:
                if (sq_stat.done)
                    d_next = sq_root[14:0];
            ST_G:
            begin
                co_start = 1'b1;
                co_y     = CO_IN_W'(big_y);
                co_x     = CO_IN_W'(big_x);
            end
            ST_GWAIT:
                if (co_stat.done)
                    g_next = co_angle;
            ST_F1:
            begin
                co_start = 1'b1;
                co_y     = CO_IN_W'(big_z);
                co_x     = CO_IN_W'(v_reg);
            end
            ST_F1WAIT:
                if (co_stat.done)
                    f1_next = co_angle;
            ST_AA:
            begin
                mul_a = MUL_W'($signed({1'b0, femur_reg}));
                mul_b = MUL_W'($signed({1'b0, femur_reg}));
            end
            ST_BB:
            begin
                acc_next = prod_reg;
                mul_a    = MUL_W'($signed({1'b0, tibia_reg}));
                mul_b    = MUL_W'($signed({1'b0, tibia_reg}));
            end
            ST_N1:
            begin
                n_next  = 31'(acc_reg + d2_reg - prod_reg);
                n2_next = 31'(acc_reg + prod_reg - d2_reg);
                mul_a   = MUL_W'($signed({1'b0, femur_reg}));
                mul_b   = MUL_W'($signed({1'b0, d_reg}));
            end
            ST_M1:
            begin
                m_next   = 29'(prod_reg <<< 1);
                sel_next = 1'b0;
            end
            ST_AC_CHK:
            begin
                mul_a = MUL_W'(m_reg);
                mul_b = MUL_W'(m_reg);
            end
            ST_AC_NN:
            begin
                acc_next = prod_reg;
                mul_a    = MUL_W'(n_reg);
                mul_b    = MUL_W'(n_reg);
            end
            ST_AC_SUB: acc_next = acc_reg - prod_reg;
            ST_AC_SQ:  sq_start = 1'b1;
            ST_AC_SQW:
                if (sq_stat.done)
                    s_next = sq_root;
            ST_AC_AT:
            begin
                co_start = 1'b1;
                co_y     = CO_IN_W'($signed({1'b0, s_reg}));
                co_x     = CO_IN_W'(n_reg);
            end
            ST_AC_ATW:
                if (co_stat.done)
                begin
                    if (sel_reg)
                        t_next = co_angle;
                    else
                        f2_next = co_angle;
                end
            ST_M2:
            begin
                n_next = n2_reg;
                mul_a  = MUL_W'($signed({1'b0, femur_reg}));
                mul_b  = MUL_W'($signed({1'b0, tibia_reg}));
            end
            ST_M2B:
            begin
                m_next   = 29'(prod_reg <<< 1);
                sel_next = 1'b1;
            end
            ST_MIR:
                if (op_reg && !pass_reg)
                begin
                    ref_next  = mir;
                    pass_next = 1'b1;
                    sx_next   = 11'(px_reg);
                    sy_next   = 11'(py_reg);
                    sz_next   = 11'(pz_reg) - $signed({3'b0, hshift_reg});
                end
                else
                begin
                    ang_next = mir;
                end
            ST_APPLY:
            begin
                for (int j = 0; j < 3; j++)
                    res_next[j] = sat_val[j][15:0];
                res_fault_next = 1'b0;
                if (op_reg)
                begin
                    for (int i = 0; i < NUM_LEGS; i++)
                    begin
                        if (32'(leg_reg) == i)
                        begin
                            for (int j = 0; j < 3; j++)
                                corr_next[i][j] = sat_val[j][ANGLE_WIDTH-1:0];
                        end
                    end
                end
            end
            ST_PARK:
            begin
                halted_next    = 1'b1;
                res_next[0]    = 16'(DEG90);
                res_next[1]    = 16'(DEG90);
                res_next[2]    = 16'({PARK_TIB[leg_reg], 6'b0});
                res_fault_next = 1'b1;
            end
            ST_FIN:
                if (!m_valid_reg || m_tready)
                begin
                    m_data_next  = {res_reg[2], res_reg[1], res_reg[0]};
                    m_fault_next = res_fault_reg;
                    m_valid_next = 1'b1;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            halted_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            femur_reg   <= 12'd848;
            tibia_reg   <= 12'd1272;
            coxa_reg    <= 12'd488;
            refx_reg    <= 10'd100;
            refy_reg    <= 10'd70;
            refz_reg    <= 10'd15;
            hshift_reg  <= 8'd27;
            for (int i = 0; i < NUM_LEGS; i++)
                for (int j = 0; j < 3; j++)
                    corr_reg[i][j] <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            halted_reg  <= halted_next;
            m_valid_reg <= m_valid_next;
            femur_reg   <= femur_next;
            tibia_reg   <= tibia_next;
            coxa_reg    <= coxa_next;
            refx_reg    <= refx_next;
            refy_reg    <= refy_next;
            refz_reg    <= refz_next;
            hshift_reg  <= hshift_next;
            corr_reg    <= corr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        leg_reg       <= leg_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        pz_reg        <= pz_next;
        pass_reg      <= pass_next;
        sel_reg       <= sel_next;
        sx_reg        <= sx_next;
        sy_reg        <= sy_next;
        sz_reg        <= sz_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        v_reg         <= v_next;
        d2_reg        <= d2_next;
        d_reg         <= d_next;
        s_reg         <= s_next;
        n_reg         <= n_next;
        n2_reg        <= n2_next;
        m_reg         <= m_next;
        g_reg         <= g_next;
        f1_reg        <= f1_next;
        f2_reg        <= f2_next;
        t_reg         <= t_next;
        ang_reg       <= ang_next;
        ref_reg       <= ref_next;
        res_reg       <= res_next;
        res_fault_reg <= res_fault_next;
        m_data_reg    <= m_data_next;
        m_fault_reg   <= m_fault_next;
    end

    lik_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .din   (sq_din),
        .stat  (sq_stat),
        .root  (sq_root)
    );

    lik_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (co_start),
        .y_in  (co_y),
        .x_in  (co_x),
        .stat  (co_stat),
        .angle (co_angle)
    );

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared without reset");

    a_fault_halted: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> halted_reg)
        else $error("fault result while not halted");

    a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!sq_stat.busy && !co_stat.busy))
        else $error("request taken while a shared unit is busy");

    a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == ST_SETUP))
        else $error("accepted request not dispatched");

endmodule
